// ===== sv/bmhq_pkg.sv =====
// constants, codes and shared types for the binary min-heap queue
// no dependencies; used by bmhq_cell and binary_min_heap_queue
`timescale 1ns / 1ps

package bmhq_pkg;

    localparam int CAPACITY    = 256;
    localparam int KEY_WIDTH   = 32;
    localparam int COUNT_WIDTH = $clog2(CAPACITY + 1);

    // operation selector carried on the slave tuser
    typedef enum logic {
        OP_PUSH = 1'b0,
        OP_POP  = 1'b1
    } op_t;

    typedef enum logic [1:0] {
        ST_OK         = 2'd0,
        ST_PUSH_FULL  = 2'd1,
        ST_POP_EMPTY  = 2'd2
    } status_t;

    typedef logic signed [KEY_WIDTH-1:0] key_t;
    typedef logic [COUNT_WIDTH-1:0]      count_t;

    // broadcast to every cell of the chain
    typedef struct packed {
        logic push_en;
        logic pop_en;
        key_t key;
    } cell_ctrl_t;

    // output tdata payload, first field in the lowest bits
    localparam int RESULT_BITS  = 2 * KEY_WIDTH + COUNT_WIDTH + 1 + 2;
    localparam int RESULT_BYTES = (RESULT_BITS + 7) / 8;
    localparam int M_DATA_WIDTH = RESULT_BYTES * 8;
    localparam int S_DATA_WIDTH = ((KEY_WIDTH + 7) / 8) * 8;

endpackage

// ===== sv/bmhq_cell.sv =====
// one slot of the sorted key chain: keeps, takes the new key, or shifts
// from a neighbour; depends on bmhq_pkg
`timescale 1ns / 1ps

module bmhq_cell (
    input  logic                aclk,
    input  bmhq_pkg::cell_ctrl_t ctrl,
    input  logic                occupied,
    input  logic                left_le,
    input  bmhq_pkg::key_t      left_key,
    input  bmhq_pkg::key_t      right_key,
    output bmhq_pkg::key_t      key_q,
    output logic                le
);

    bmhq_pkg::key_t key_reg;
    bmhq_pkg::key_t key_next;

    // stored key sorts at or before the incoming one
    assign le    = occupied && (key_reg <= ctrl.key);
    assign key_q = key_reg;

    always_comb begin
        key_next = key_reg;
        if (ctrl.push_en) begin
            if (!le) begin
                // insertion point is here when the left neighbour stays put
                key_next = left_le ? ctrl.key : left_key;
            end
        end else if (ctrl.pop_en) begin
            key_next = right_key;
        end
    end

    always_ff @(posedge aclk) begin
        key_reg <= key_next;
    end

endmodule

// ===== sv/binary_min_heap_queue.sv =====
// priority queue of signed keys, top level: handshake, fill count and a
// chain of bmhq_cell slots kept in ascending order; depends on bmhq_pkg
`timescale 1ns / 1ps

// usage
//   slave channel: s_tuser selects the operation (0 push, 1 pop) and
//   s_tdata carries the signed key, ignored on a pop.
//   master channel: one result transaction per input transaction, giving
//   the popped key, the new minimum, the count, an empty flag and a status
//   (0 ok, 1 push rejected because full, 2 pop rejected because empty).
//   output: the result is registered and shows in the cycle after the input
//   transaction. throughput: one transaction per cycle while no result is
//   left waiting on m_tready, set by the chain of slots, each of which
//   compares itself with the broadcast key and either keeps its key, takes
//   the new key or takes a neighbour's key.
//   reset: aresetn low at a clock edge empties the queue and drops any
//   pending result; slot contents are not cleared since the fill count
//   alone marks which slots hold keys.
//   stall: while a result waits on m_tready the block still takes one more
//   input only in the cycle the waiting result is taken; otherwise s_tready
//   stays low and the queue holds its state.
module binary_min_heap_queue (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [bmhq_pkg::S_DATA_WIDTH-1:0] s_tdata,  // key
    input  logic                              s_tuser,  // mode
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // popped_key, min_key, count, is_empty, status, zero fill
    output logic [bmhq_pkg::M_DATA_WIDTH-1:0] m_tdata
);

    localparam int CAP = bmhq_pkg::CAPACITY;
    localparam int KW  = bmhq_pkg::KEY_WIDTH;
    localparam int CW  = bmhq_pkg::COUNT_WIDTH;

    bmhq_pkg::count_t count_reg;
    bmhq_pkg::count_t count_next;
    logic             m_tvalid_reg;
    logic             m_tvalid_next;
    logic [bmhq_pkg::M_DATA_WIDTH-1:0] m_tdata_reg;
    logic [bmhq_pkg::M_DATA_WIDTH-1:0] m_tdata_next;

    bmhq_pkg::cell_ctrl_t ctrl;
    bmhq_pkg::key_t       chain_key [CAP];
    logic [CAP-1:0]       chain_le;

    logic                 accept;
    logic                 is_full;
    logic                 is_zero;
    bmhq_pkg::key_t       in_key;
    bmhq_pkg::key_t       popped;
    bmhq_pkg::key_t       min_next;
    bmhq_pkg::status_t    status;

    assign s_tready = !m_tvalid_reg || m_tready;
    assign accept   = s_tvalid && s_tready;
    assign in_key   = s_tdata[KW-1:0];
    assign is_full  = (count_reg == CW'(CAP));
    assign is_zero  = (count_reg == '0);

    assign ctrl.key     = in_key;
    assign ctrl.push_en = accept && (s_tuser == bmhq_pkg::OP_PUSH) && !is_full;
    assign ctrl.pop_en  = accept && (s_tuser == bmhq_pkg::OP_POP) && !is_zero;

    for (genvar i = 0; i < CAP; i++) begin : g_cell
        logic           occupied;
        logic           left_le;
        bmhq_pkg::key_t left_key;
        bmhq_pkg::key_t right_key;

        assign occupied = (count_reg > CW'(i));
        if (i == 0) begin : g_head
            // head slot always sits right of an imaginary smaller key
            assign left_le  = 1'b1;
            assign left_key = in_key;
        end else begin : g_body
            assign left_le  = chain_le[i-1];
            assign left_key = chain_key[i-1];
        end
        if (i == CAP - 1) begin : g_tail
            assign right_key = chain_key[i];
        end else begin : g_inner
            assign right_key = chain_key[i+1];
        end

        bmhq_cell u_cell (
            .aclk      (aclk),
            .ctrl      (ctrl),
            .occupied  (occupied),
            .left_le   (left_le),
            .left_key  (left_key),
            .right_key (right_key),
            .key_q     (chain_key[i]),
            .le        (chain_le[i])
        );
    end

    always_comb begin
        count_next = count_reg;
        popped     = '0;
        status     = bmhq_pkg::ST_OK;
        min_next   = is_zero ? '0 : chain_key[0];
        if (s_tuser == bmhq_pkg::OP_PUSH) begin
            if (is_full) begin
                status = bmhq_pkg::ST_PUSH_FULL;
            end else begin
                count_next = count_reg + CW'(1);
                if (is_zero || (in_key < chain_key[0])) begin
                    min_next = in_key;
                end
            end
        end else begin
            if (is_zero) begin
                status = bmhq_pkg::ST_POP_EMPTY;
            end else begin
                count_next = count_reg - CW'(1);
                popped     = chain_key[0];
                // next in order becomes the head unless the queue runs dry
                min_next   = (count_reg > CW'(1)) ? chain_key[1] : '0;
            end
        end
    end

    always_comb begin
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        if (accept) begin
            m_tvalid_next = 1'b1;
            m_tdata_next  = '0;
            m_tdata_next[KW-1:0]          = popped;
            m_tdata_next[2*KW-1:KW]       = min_next;
            m_tdata_next[2*KW+CW-1:2*KW]  = count_next;
            m_tdata_next[2*KW+CW]         = (count_next == '0);
            m_tdata_next[2*KW+CW+2:2*KW+CW+1] = status;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            if (accept) begin
                count_reg <= count_next;
            end
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

endmodule
